// ----- rtl/dsf_pkg.sv -----
// shared widths, defaults and the query word type for the duplicate filter
package dsf_pkg;

    localparam int DSF_ADDR_W          = 48;
    localparam int DSF_SEQ_W           = 16;
    localparam int DSF_TABLE_ENTRIES   = 32;

    // query word walking down the cell chain
    typedef struct packed {
        logic                  valid;
        logic                  done;
        logic                  is_new;
        logic                  inserted;
        logic [DSF_ADDR_W-1:0] src_addr;
        logic [DSF_SEQ_W-1:0]  seq_num;
    } t_token;

endpackage

// ----- rtl/dsf_if.sv -----
// valid/ready channel interfaces for input and result words of the duplicate filter
interface dsf_in_if import dsf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [DSF_ADDR_W-1:0] src_addr;
    logic [DSF_SEQ_W-1:0]  seq_num;

    modport source (output valid, output src_addr, output seq_num, input ready);
    modport sink   (input valid, input src_addr, input seq_num, output ready);
endinterface

interface dsf_out_if ();
    logic valid;
    logic ready;
    logic is_new;
    logic table_full;

    modport source (output valid, output is_new, output table_full, input ready);
    modport sink   (input valid, input is_new, input table_full, output ready);
endinterface

// ----- rtl/dsf_cell.sv -----
// one table entry of the filter chain: compares, updates or claims, then hands the word on
module dsf_cell
    import dsf_pkg::*;
#(
    parameter int TABLE_ENTRIES = DSF_TABLE_ENTRIES,
    parameter int IDX           = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [$clog2(TABLE_ENTRIES+1)-1:0]   i_count,
    input  t_token                               i_tok,
    output t_token                               o_tok
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [DSF_ADDR_W-1:0] r_src;
    logic [DSF_SEQ_W-1:0]  r_seq;
    t_token                r_tok;
    t_token                n_tok;
    logic                  w_occupied;
    logic                  w_active;
    logic                  w_match;
    logic                  w_claim;
    logic                  w_newer;

    // entry state as seen by the passing word
    assign w_occupied = (IDX_C < i_count);
    assign w_active   = i_tok.valid && !i_tok.done;
    assign w_match    = w_active && w_occupied && (r_src == i_tok.src_addr);
    assign w_claim    = w_active && (IDX_C == i_count);
    assign w_newer    = (i_tok.seq_num > r_seq);

    // resolve the word here or pass it unchanged
    always_comb begin
        n_tok = i_tok;
        if (w_match) begin
            n_tok.done   = 1'b1;
            n_tok.is_new = w_newer;
        end else if (w_claim) begin
            n_tok.done     = 1'b1;
            n_tok.is_new   = 1'b1;
            n_tok.inserted = 1'b1;
        end
    end

    // entry storage, written only on a claim or a newer sequence
    always_ff @(posedge i_clk) begin
        if (w_claim) begin
            r_src <= i_tok.src_addr;
            r_seq <= i_tok.seq_num;
        end else if (w_match && w_newer) begin
            r_seq <= i_tok.seq_num;
        end
    end

    // hand-off register to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.done     <= n_tok.done;
        r_tok.is_new   <= n_tok.is_new;
        r_tok.inserted <= n_tok.inserted;
        r_tok.src_addr <= n_tok.src_addr;
        r_tok.seq_num  <= n_tok.seq_num;
    end

    assign o_tok = r_tok;

endmodule

// ----- rtl/duplicate_sequence_filter.sv -----
// top level of the receive-side duplicate sequence filter
//
//  port    dir   fields                 handshake
//  i_in    in    src_addr, seq_num      valid/ready, taken when both high
//  o_out   out   is_new, table_full     valid/ready, taken when both high
//
// one word at a time: a word walks the row of TABLE_ENTRIES cells, one cell per cycle,
// then lands in the result register; i_in.ready stays low from the accept on and
// returns the cycle after the result is taken, so a new word waits for that.
// the length of the cell row sets the latency.
// reset (synchronous, active low) empties the table by clearing the fill count.
// a stalled result holds; no new word is taken until it is delivered.
module duplicate_sequence_filter
    import dsf_pkg::*;
#(
    parameter int TABLE_ENTRIES = DSF_TABLE_ENTRIES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dsf_in_if.sink          i_in,
    dsf_out_if.source       o_out
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_C = CNT_W'(TABLE_ENTRIES);

    logic             r_busy;
    logic [CNT_W-1:0] r_count;
    logic             r_out_valid;
    logic             r_is_new;
    logic             r_full;
    logic             w_in_acc;
    logic             w_out_acc;
    t_token           w_tok [TABLE_ENTRIES+1];
    t_token           w_tail;

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;

    // word entering the first cell
    assign w_tok[0] = '{valid:    w_in_acc,
                        done:     1'b0,
                        is_new:   1'b0,
                        inserted: 1'b0,
                        src_addr: i_in.src_addr,
                        seq_num:  i_in.seq_num};

    // the cell row
    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        dsf_cell #(
            .TABLE_ENTRIES(TABLE_ENTRIES),
            .IDX          (k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_count(r_count),
            .i_tok  (w_tok[k]),
            .o_tok  (w_tok[k+1])
        );
    end

    assign w_tail = w_tok[TABLE_ENTRIES];

    // busy from accept until the result word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_in_acc) begin
            r_busy <= 1'b1;
        end else if (w_out_acc) begin
            r_busy <= 1'b0;
        end
    end

    // fill count, bumped when a word claimed a free cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_tail.valid && w_tail.inserted) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // result register; an unresolved word means the table is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_tail.valid) begin
            r_out_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
        if (w_tail.valid) begin
            r_is_new <= w_tail.done ? w_tail.is_new : 1'b1;
            r_full   <= !w_tail.done;
        end
    end

    assign i_in.ready       = !r_busy;
    assign o_out.valid      = r_out_valid;
    assign o_out.is_new     = r_is_new;
    assign o_out.table_full = r_full;

    // checks
    a_out_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_busy)
        else $error("result pending while not busy");

    a_full_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tail.valid && !w_tail.done) |-> (r_count == FULL_C))
        else $error("word fell off the row with free cells left");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_C)
        else $error("fill count above table size");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.valid |-> !r_out_valid)
        else $error("result register overwritten");

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_busy && !i_in.ready))
        else $error("second word taken while one in flight");

endmodule
